// ===== hdl/rfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared types, widths and helpers for the rectifier + FIR envelope block.
// ----------------------------------------------------------------------------
package rfe_pkg;

    localparam int TAPS       = 8;   // active FIR taps, 1..8
    localparam int NCOEF      = 8;   // coefficient registers
    localparam int NSLOT      = 8;   // adder tree inputs
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 34;
    localparam int CFG_IDX_W  = 4;
    localparam int CNT_W      = $clog2(TAPS + 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic        [CNT_W-1:0]    flush_cnt_t;

    // per-stage control that travels alongside the data
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    localparam sample_t SAMPLE_MIN = sample_t'(1) << (SAMPLE_W - 1);
    localparam mag_t    MAG_MAX    = '1;

    // full-wave rectify; most negative code saturates
    function automatic mag_t rectify(input sample_t s);
        sample_t neg;
        mag_t    m;
        begin
            neg = -s;
            if (s == SAMPLE_MIN)
                m = MAG_MAX;
            else if (s[SAMPLE_W-1])
                m = neg[MAG_W-1:0];
            else
                m = s[MAG_W-1:0];
            return m;
        end
    endfunction

endpackage

// ===== hdl/rfe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe channel interfaces
// Valid/ready channels for samples in, results out and register writes.
// ----------------------------------------------------------------------------
interface rfe_in_if;
    logic             valid;
    logic             ready;
    rfe_pkg::sample_t sample;
    logic             last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface rfe_out_if;
    logic          valid;
    logic          ready;
    rfe_pkg::sum_t filtered_value;
    logic          last_result;

    modport source (output valid, output filtered_value, output last_result, input ready);
    modport sink   (input valid, input filtered_value, input last_result, output ready);
endinterface

interface rfe_cfg_if;
    logic              valid;
    logic              ready;
    rfe_pkg::cfg_idx_t index;
    rfe_pkg::coef_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rectify_fir_envelope.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectify_fir_envelope
// Full-wave rectifier feeding an 8-tap FIR built as a chain of tap cells.
// ----------------------------------------------------------------------------
// Usage:
//   smp : sample words (signed sample, last_sample). One word per cycle while smp.ready is high.
//   res : result words (34-bit filtered_value, last_result).
//   cfg : coefficient writes, index 0..7 = coef_0..coef_7, always ready;
//         indexes 8 and up are dropped. Write only while the block is idle.
// Each sample gives one result after the tap, product and adder registers;
// a full pipeline sustains one sample per cycle while res is not stalled.
// A word marked last_sample adds TAPS flush results (zeros pushed through
// the tap chain), one per cycle while res is not stalled; smp.ready stays
// low until all are injected. The final flush result is 0 and carries
// last_result; the tap chain is then clear again. The five-stage pipe (tap
// chain, product registers, three adder levels) sets the rate and moves one
// word per cycle; when res is stalled the whole pipe holds and smp.ready
// drops at once. Reset clears the taps, the coefficients and all valid bits.
// ----------------------------------------------------------------------------
module rectify_fir_envelope (
    input logic      clk,
    input logic      rst_n,
    rfe_in_if.sink   smp,
    rfe_out_if.source res,
    rfe_cfg_if.sink  cfg
);
    import rfe_pkg::*;

    logic       adv;
    logic       accept;
    logic       flushing;
    logic       flush_inject;
    logic       inject;
    mag_t       inject_mag;
    flush_cnt_t flush_cnt_reg, flush_cnt_next;
    ctl_t       v0_reg, v0_next;
    ctl_t       v1_reg;
    ctl_t       tree_ctl;
    mag_t       taps  [TAPS];
    prod_t      prods [NSLOT];
    logic       coef_we [NCOEF];
    logic       taps_zero;

    // pipe moves whenever the output register is free or being drained
    assign adv          = !res.valid || res.ready;
    assign flushing     = (flush_cnt_reg != '0);
    assign smp.ready    = adv && !flushing;
    assign accept       = smp.valid && smp.ready;
    assign flush_inject = flushing && adv;
    assign inject       = accept || flush_inject;
    assign inject_mag   = flushing ? '0 : rectify(smp.sample);

    always_comb
    begin
        flush_cnt_next = flush_cnt_reg;
        if (accept && smp.last_sample)
            flush_cnt_next = flush_cnt_t'(TAPS);
        else if (flush_inject)
            flush_cnt_next = flush_cnt_reg - flush_cnt_t'(1);

        v0_next.valid = inject;
        v0_next.last  = flush_inject && (flush_cnt_reg == flush_cnt_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_cnt_reg <= '0;
            v0_reg        <= '0;
            v1_reg        <= '0;
        end
        else
        begin
            flush_cnt_reg <= flush_cnt_next;
            if (adv)
            begin
                v0_reg <= v0_next;
                v1_reg <= v0_reg;
            end
        end
    end

    // coefficient write decode
    assign cfg.ready = 1'b1;
    always_comb
    begin
        for (int k = 0; k < NCOEF; k++)
            coef_we[k] = cfg.valid && (cfg.index == cfg_idx_t'(k));
    end

    // tap chain
    genvar gk;
    generate
        for (gk = 0; gk < NSLOT; gk++)
        begin : g_tap
            if (gk < TAPS)
            begin : g_cell
                mag_t x_in;
                if (gk == 0)
                begin : g_head
                    assign x_in = inject_mag;
                end
                else
                begin : g_body
                    assign x_in = taps[gk-1];
                end

                rfe_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .adv        (adv),
                    .shift      (inject),
                    .x_in       (x_in),
                    .coef_we    (coef_we[gk]),
                    .coef_wdata (cfg.data),
                    .x_out      (taps[gk]),
                    .prod       (prods[gk])
                );
            end
            else
            begin : g_pad
                assign prods[gk] = '0;
            end
        end
    endgenerate

    rfe_sum_tree u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (v1_reg),
        .prods   (prods),
        .ctl_out (tree_ctl),
        .sum     (res.filtered_value)
    );

    assign res.valid       = tree_ctl.valid;
    assign res.last_result = tree_ctl.last;

    always_comb
    begin
        taps_zero = 1'b1;
        for (int k = 0; k < TAPS; k++)
            if (taps[k] != '0)
                taps_zero = 1'b0;
    end

`ifndef ASSERT_OFF
    a_flush_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && smp.last_sample) |=> (flush_cnt_reg == flush_cnt_t'(TAPS)))
        else $error("flush count not loaded after last sample");

    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last_result) |-> (res.filtered_value == '0))
        else $error("final flush result is not zero");

    a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (inject && v0_next.last) |=> taps_zero)
        else $error("tap chain not clear after flush");

    a_flush_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && smp.last_sample) |=> !smp.ready)
        else $error("sample taken during flush");
`endif

endmodule

// ===== hdl/rfe_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_cell
// One FIR tap: holds a magnitude of the delay line and its coefficient,
// passes the magnitude on to the next cell and registers the tap product.
// ----------------------------------------------------------------------------
module rfe_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           shift,
    input  rfe_pkg::mag_t  x_in,
    input  logic           coef_we,
    input  rfe_pkg::coef_t coef_wdata,
    output rfe_pkg::mag_t  x_out,
    output rfe_pkg::prod_t prod
);
    import rfe_pkg::*;

    mag_t                 tap_reg;
    coef_t                coef_reg;
    prod_t                prod_reg;
    prod_t                prod_next;
    logic signed [MAG_W:0] tap_s;

    always_comb
    begin
        tap_s     = $signed({1'b0, tap_reg});
        prod_next = coef_reg * tap_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            if (shift)
                tap_reg <= x_in;
            if (coef_we)
                coef_reg <= coef_wdata;
        end
    end

    // product follows the word in the tap stage
    always_ff @(posedge clk)
    begin
        if (adv)
            prod_reg <= prod_next;
    end

    assign x_out = tap_reg;
    assign prod  = prod_reg;

endmodule

// ===== hdl/rfe_sum_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_sum_tree
// Registered three-level adder tree over the tap products; the last level
// is the output register.
// ----------------------------------------------------------------------------
module rfe_sum_tree (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  rfe_pkg::ctl_t  ctl_in,
    input  rfe_pkg::prod_t prods [rfe_pkg::NSLOT],
    output rfe_pkg::ctl_t  ctl_out,
    output rfe_pkg::sum_t  sum
);
    import rfe_pkg::*;

    localparam int L1_N = NSLOT / 2;
    localparam int L2_N = NSLOT / 4;

    sum_t l1_reg  [L1_N];
    sum_t l1_next [L1_N];
    sum_t l2_reg  [L2_N];
    sum_t l2_next [L2_N];
    sum_t l3_reg;
    sum_t l3_next;
    ctl_t c1_reg, c2_reg, c3_reg;

    always_comb
    begin
        for (int i = 0; i < L1_N; i++)
            l1_next[i] = sum_t'(prods[2*i]) + sum_t'(prods[2*i+1]);
        for (int i = 0; i < L2_N; i++)
            l2_next[i] = l1_reg[2*i] + l1_reg[2*i+1];
        l3_next = l2_reg[0] + l2_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg <= l1_next;
            l2_reg <= l2_next;
            l3_reg <= l3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= ctl_in;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    assign ctl_out = c3_reg;
    assign sum     = l3_reg;

endmodule
